### rtl/prc_pkg.sv
// ----------------------------------------------------------------------------
// Packet rule classifier package
// Shared types and codes of the rule classifier with flow aging.
// ----------------------------------------------------------------------------
`default_nettype none

package prc_pkg;

   localparam int IDX_W = 8;

   localparam logic [1:0] REQ_CLASSIFY = 2'd0;
   localparam logic [1:0] REQ_LOAD     = 2'd1;
   localparam logic [1:0] REQ_CLEAR    = 2'd2;

   localparam logic [3:0] KIND_NONE    = 4'd0;
   localparam logic [3:0] KIND_SMAC    = 4'd1;
   localparam logic [3:0] KIND_DMAC    = 4'd2;
   localparam logic [3:0] KIND_SIP     = 4'd3;
   localparam logic [3:0] KIND_DIP     = 4'd4;
   localparam logic [3:0] KIND_TCP     = 4'd5;
   localparam logic [3:0] KIND_UDP     = 4'd6;
   localparam logic [3:0] KIND_TCPPORT = 4'd7;
   localparam logic [3:0] KIND_UDPPORT = 4'd8;

   localparam logic [7:0] PROTO_TCP = 8'h06;
   localparam logic [7:0] PROTO_UDP = 8'h11;

   localparam logic [1:0] CSR_DYN_EN  = 2'd0;
   localparam logic [1:0] CSR_TIMEOUT = 2'd1;
   localparam logic [1:0] CSR_VLAN_A  = 2'd2;
   localparam logic [1:0] CSR_VLAN_B  = 2'd3;

   localparam logic [15:0] TIMEOUT_RESET = 16'd180;
   localparam logic [11:0] VLAN_A_RESET  = 12'd5;
   localparam logic [11:0] VLAN_B_RESET  = 12'd6;

   localparam logic [47:0] BYTES_MAX = 48'hFFFF_FFFF_FFFF;
   localparam logic [4:0]  EXP_MAX   = 5'd31;

   typedef struct packed {
      logic [47:0] src_mac;
      logic [47:0] dst_mac;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [7:0]  proto;
      logic [15:0] port;
      logic [31:0] now;
      logic [15:0] timeout;
   } frame_type;

   typedef struct packed {
      logic             en;
      logic             clr;
      logic [IDX_W-1:0] idx;
      logic [3:0]       kind;
      logic [47:0]      key;
      logic [11:0]      vlan;
      logic             dynamic;
      logic [31:0]      stamp;
   } slot_wr_type;

   typedef struct packed {
      logic             active;
      logic             found;
      logic [IDX_W-1:0] slot;
      logic [11:0]      vlan;
      logic [4:0]       exp;
      logic             free_found;
      logic [IDX_W-1:0] free_idx;
   } token_type;

endpackage

`default_nettype wire

### rtl/prc_cell.sv
// ----------------------------------------------------------------------------
// Rule cell
// Holds one rule slot and updates the scan token passing through it.
// ----------------------------------------------------------------------------
`default_nettype none

module prc_cell import prc_pkg::*; #(
   parameter logic [IDX_W-1:0] CELL_IDX = 8'd0
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire frame_type   frame,
   input  wire slot_wr_type wr,
   input  wire token_type   tok_in,
   output token_type        tok_out
);

   logic        valid_ff, dynamic_ff;
   logic [3:0]  kind_ff;
   logic [47:0] key_ff;
   logic [11:0] vlan_ff;
   logic [31:0] stamp_ff;
   token_type   tok_ff, tok_in_next;
   logic        match, expired, del;
   logic [31:0] age;

   always_comb begin
      case (kind_ff)
         KIND_SMAC:    match = key_ff == frame.src_mac;
         KIND_DMAC:    match = key_ff == frame.dst_mac;
         KIND_SIP:     match = key_ff == {16'd0, frame.src_ip};
         KIND_DIP:     match = key_ff == {16'd0, frame.dst_ip};
         KIND_TCP:     match = frame.proto == PROTO_TCP;
         KIND_UDP:     match = frame.proto == PROTO_UDP;
         KIND_TCPPORT: match = frame.proto == PROTO_TCP && key_ff == {32'd0, frame.port};
         KIND_UDPPORT: match = frame.proto == PROTO_UDP && key_ff == {32'd0, frame.port};
         default:      match = 1'b0;
      endcase
      match   = match && valid_ff;
      age     = frame.now - stamp_ff;
      expired = dynamic_ff && (age > {16'd0, frame.timeout});
   end

   always_comb begin
      tok_in_next = tok_in;
      del = 1'b0;
      if (tok_in.active) begin
         if (!tok_in.found && match) begin
            if (expired) begin
               del = 1'b1;
               if (tok_in.exp != EXP_MAX) begin
                  tok_in_next.exp = tok_in.exp + 5'd1;
               end
            end else begin
               tok_in_next.found = 1'b1;
               tok_in_next.slot  = CELL_IDX;
               tok_in_next.vlan  = vlan_ff;
            end
         end
         if (!tok_in.free_found && !(valid_ff && !del)) begin
            tok_in_next.free_found = 1'b1;
            tok_in_next.free_idx   = CELL_IDX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         dynamic_ff    <= 1'b0;
         kind_ff       <= KIND_NONE;
         tok_ff.active <= 1'b0;
      end else begin
         tok_ff <= tok_in_next;
         if (wr.en && wr.idx == CELL_IDX) begin
            if (wr.clr) begin
               valid_ff   <= 1'b0;
               dynamic_ff <= 1'b0;
               kind_ff    <= KIND_NONE;
            end else begin
               valid_ff   <= 1'b1;
               dynamic_ff <= wr.dynamic;
               kind_ff    <= wr.kind;
            end
         end else if (del) begin
            valid_ff   <= 1'b0;
            dynamic_ff <= 1'b0;
            kind_ff    <= KIND_NONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en && !wr.clr && wr.idx == CELL_IDX) begin
         key_ff   <= wr.key;
         vlan_ff  <= wr.vlan;
         stamp_ff <= wr.stamp;
      end
   end

   assign tok_out = tok_ff;

endmodule

`default_nettype wire

### rtl/packet_rule_classifier_with_aging_top.sv
// ----------------------------------------------------------------------------
// Packet rule classifier with flow aging
// Ordered first-match rule table built as a row of rule cells.
// ----------------------------------------------------------------------------
// Requests enter on the req_ channel and each gives one result on the rsp_
// channel; a transfer happens when valid is high and stall is low. Registers
// are written through the csr_ channel, which is always ready.
// A classify request sends a scan token through the row of RULE_SLOTS cells,
// one cell per cycle; the token is then captured from the last cell and the
// result is registered for the rsp_ channel. Load and clear requests write
// their slot at the transfer and answer from ST_FIN. req_stall stays high
// from a transfer until its result is registered, so the block takes no new
// request before it is done with the last one; rsp_stall can hold it longer.
// While rsp_stall is high a finished result waits in the output register and
// the block holds the next finished result until that register is free.
// Reset clears all rules, both byte counters and the registers to their
// default values.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_rule_classifier_with_aging_top import prc_pkg::*; #(
   parameter int RULE_SLOTS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_type,
   input  wire logic [47:0] req_src_mac,
   input  wire logic [47:0] req_dst_mac,
   input  wire logic [31:0] req_src_ip,
   input  wire logic [31:0] req_dst_ip,
   input  wire logic [7:0]  req_ip_proto,
   input  wire logic [15:0] req_dst_port,
   input  wire logic [15:0] req_frame_len,
   input  wire logic [31:0] req_now_sec,
   input  wire logic [3:0]  req_slot_index,
   input  wire logic [3:0]  req_rule_kind,
   input  wire logic [11:0] req_rule_vlan,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [11:0]      rsp_out_vlan,
   output logic             rsp_hit,
   output logic [3:0]       rsp_hit_slot,
   output logic             rsp_rule_added,
   output logic             rsp_table_full,
   output logic [4:0]       rsp_expired_count,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_FIN  = 3'b100
   } state_type;

   state_type   state_ff, state_in;
   logic        dyn_en_ff;
   logic [15:0] timeout_ff;
   logic [11:0] vlan_a_ff, vlan_b_ff;
   logic [47:0] bytes_a_ff, bytes_b_ff;
   frame_type   frame_ff;
   logic [15:0] len_ff;
   logic        cls_ff, start_ff;
   token_type   tok_ff, tok_start;
   token_type   tok_chain [RULE_SLOTS+1];
   slot_wr_type wr;
   logic        req_xfer, out_free, finish;
   logic [11:0] bal_vlan;
   logic        do_add, do_full;
   logic [48:0] sum_a, sum_b;

   assign req_xfer  = req_valid && !req_stall;
   assign req_stall = state_ff != ST_IDLE;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid || !rsp_stall;
   assign finish    = state_ff == ST_FIN && out_free;

   always_comb begin
      tok_start        = '0;
      tok_start.active = start_ff;
   end

   assign tok_chain[0] = tok_start;

   for (genvar i = 0; i < RULE_SLOTS; i++) begin : g_cell
      prc_cell #(.CELL_IDX(IDX_W'(i))) u_cell (
         .clock   (clock),
         .reset   (reset),
         .frame   (frame_ff),
         .wr      (wr),
         .tok_in  (tok_chain[i]),
         .tok_out (tok_chain[i+1])
      );
   end

   assign bal_vlan = (bytes_a_ff < bytes_b_ff) ? vlan_a_ff : vlan_b_ff;
   assign do_add   = cls_ff && !tok_ff.found && dyn_en_ff && tok_ff.free_found;
   assign do_full  = cls_ff && !tok_ff.found && dyn_en_ff && !tok_ff.free_found;
   assign sum_a    = {1'b0, bytes_a_ff} + {33'd0, len_ff};
   assign sum_b    = {1'b0, bytes_b_ff} + {33'd0, len_ff};

   always_comb begin
      wr = '0;
      if (req_xfer && (req_type == REQ_LOAD || req_type == REQ_CLEAR)) begin
         wr.en  = 1'b1;
         wr.idx = {{(IDX_W-4){1'b0}}, req_slot_index};
         wr.clr = req_type == REQ_CLEAR || req_rule_kind < KIND_SMAC
               || req_rule_kind > KIND_UDPPORT;
         wr.kind = req_rule_kind;
         wr.vlan = req_rule_vlan;
         case (req_rule_kind)
            KIND_SMAC:    wr.key = req_src_mac;
            KIND_DMAC:    wr.key = req_dst_mac;
            KIND_SIP:     wr.key = {16'd0, req_src_ip};
            KIND_DIP:     wr.key = {16'd0, req_dst_ip};
            KIND_TCPPORT: wr.key = {32'd0, req_dst_port};
            KIND_UDPPORT: wr.key = {32'd0, req_dst_port};
            default:      wr.key = '0;
         endcase
      end else if (finish && do_add) begin
         wr.en      = 1'b1;
         wr.idx     = tok_ff.free_idx;
         wr.kind    = KIND_SMAC;
         wr.key     = frame_ff.src_mac;
         wr.vlan    = bal_vlan;
         wr.dynamic = 1'b1;
         wr.stamp   = frame_ff.now;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = (req_type == REQ_CLASSIFY) ? ST_SCAN : ST_FIN;
            end
         end
         ST_SCAN: begin
            if (tok_chain[RULE_SLOTS].active) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         start_ff   <= 1'b0;
         cls_ff     <= 1'b0;
         rsp_valid  <= 1'b0;
         dyn_en_ff  <= 1'b0;
         timeout_ff <= TIMEOUT_RESET;
         vlan_a_ff  <= VLAN_A_RESET;
         vlan_b_ff  <= VLAN_B_RESET;
         bytes_a_ff <= '0;
         bytes_b_ff <= '0;
      end else begin
         state_ff <= state_in;
         start_ff <= req_xfer && req_type == REQ_CLASSIFY;
         if (req_xfer) begin
            cls_ff <= req_type == REQ_CLASSIFY;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DYN_EN:  dyn_en_ff  <= csr_wdata[0];
               CSR_TIMEOUT: timeout_ff <= csr_wdata;
               CSR_VLAN_A:  vlan_a_ff  <= csr_wdata[11:0];
               CSR_VLAN_B:  vlan_b_ff  <= csr_wdata[11:0];
               default: ;
            endcase
         end
         if (finish) begin
            rsp_valid <= 1'b1;
            if (cls_ff && tok_ff.found) begin
               if (tok_ff.vlan == vlan_a_ff) begin
                  bytes_a_ff <= sum_a[48] ? BYTES_MAX : sum_a[47:0];
               end
               if (tok_ff.vlan == vlan_b_ff) begin
                  bytes_b_ff <= sum_b[48] ? BYTES_MAX : sum_b[47:0];
               end
            end
         end else if (!rsp_stall) begin
            rsp_valid <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         frame_ff.src_mac <= req_src_mac;
         frame_ff.dst_mac <= req_dst_mac;
         frame_ff.src_ip  <= req_src_ip;
         frame_ff.dst_ip  <= req_dst_ip;
         frame_ff.proto   <= req_ip_proto;
         frame_ff.port    <= req_dst_port;
         frame_ff.now     <= req_now_sec;
         frame_ff.timeout <= timeout_ff;
         len_ff           <= req_frame_len;
         tok_ff           <= '0;
      end else if (state_ff == ST_SCAN && tok_chain[RULE_SLOTS].active) begin
         tok_ff <= tok_chain[RULE_SLOTS];
      end
      if (finish) begin
         rsp_hit           <= cls_ff && tok_ff.found;
         rsp_rule_added    <= do_add;
         rsp_table_full    <= do_full;
         rsp_expired_count <= cls_ff ? tok_ff.exp : 5'd0;
         if (cls_ff && tok_ff.found) begin
            rsp_out_vlan <= tok_ff.vlan;
            rsp_hit_slot <= tok_ff.slot[3:0];
         end else if (cls_ff && dyn_en_ff) begin
            rsp_out_vlan <= bal_vlan;
            rsp_hit_slot <= do_add ? tok_ff.free_idx[3:0] : 4'd0;
         end else begin
            rsp_out_vlan <= 12'd0;
            rsp_hit_slot <= 4'd0;
         end
      end
   end

`ifndef SYNTHESIS
   a_token_in_scan: assert property (@(posedge clock) disable iff (reset)
      tok_chain[RULE_SLOTS].active |-> state_ff == ST_SCAN)
      else $error("Scan token left the cell row outside a scan.");
   a_hit_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> !rsp_rule_added && !rsp_table_full)
      else $error("A hit result also reports an insertion outcome.");
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff != ST_IDLE)
      else $error("Request transfer did not start any work.");
`endif

endmodule

`default_nettype wire
